FILE: rtl/core/mma_pkg.sv
package mma_pkg;

    // Storage geometry. Both matrices and the accumulator use a square
    // MAX_DIM x MAX_DIM store addressed as row * MAX_DIM + col.
    localparam int MAX_DIM = 16;
    localparam int DIM_W   = $clog2(MAX_DIM);
    localparam int CNT_W   = $clog2(MAX_DIM + 1);
    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int ADDR_W  = $clog2(DEPTH);

    // Word widths of the ports.
    localparam int FUNC_W    = 3;
    localparam int IDX_W     = 4;
    localparam int AB_W      = 16;
    localparam int C_W       = 48;
    localparam int PROD_W    = 2 * AB_W;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 2;

    // Function codes of a command word.
    localparam logic [FUNC_W-1:0] FUNC_WRITE_A = FUNC_W'(0);
    localparam logic [FUNC_W-1:0] FUNC_WRITE_B = FUNC_W'(1);
    localparam logic [FUNC_W-1:0] FUNC_WRITE_C = FUNC_W'(2);
    localparam logic [FUNC_W-1:0] FUNC_COMPUTE = FUNC_W'(3);
    localparam logic [FUNC_W-1:0] FUNC_READ_C  = FUNC_W'(4);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = CFG_IDX_W'(2);

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

    // Saturation limits of the Q24.24 accumulator.
    localparam logic signed [C_W-1:0] C_MAX = {1'b0, {(C_W - 1){1'b1}}};
    localparam logic signed [C_W-1:0] C_MIN = {1'b1, {(C_W - 1){1'b0}}};

    // Tag that travels with each multiply-accumulate step.
    typedef struct packed {
        logic              valid;
        logic              first;
        logic              last;
        logic [ADDR_W-1:0] addr;
    } mac_tag_t;

    // Write-back and status from the multiply-accumulate unit.
    typedef struct packed {
        logic                    active;
        logic                    wr_en;
        logic [ADDR_W-1:0]       wr_addr;
        logic signed [C_W-1:0]   wr_data;
        logic                    sat;
    } mac_out_t;

    // A dimension register above MAX_DIM acts as MAX_DIM.
    function automatic logic [CNT_W-1:0] clamp_dim(input logic [CFG_W-1:0] d);
        logic [CNT_W-1:0] r;
        if (32'(d) > 32'(MAX_DIM))
        begin
            r = CNT_W'(MAX_DIM);
        end
        else
        begin
            r = CNT_W'(d);
        end
        return r;
    endfunction

    // Linear store address of an element.
    function automatic logic [ADDR_W-1:0] mem_addr(input logic [DIM_W-1:0] r,
                                                   input logic [DIM_W-1:0] c);
        return ADDR_W'(r) * ADDR_W'(MAX_DIM) + ADDR_W'(c);
    endfunction

endpackage

FILE: rtl/core/matrix_multiply_accumulate.sv
// Fixed-point matrix multiply-accumulate: C += A * B on 16x16 stores, with A and B
// in signed Q4.12 and C a saturating signed Q24.24 accumulator cleared at reset.
// Write and read words are taken one per cycle while busy is low; a read-C word
// returns its element with done high for exactly one cycle, in the cycle after the
// word was taken, and the receiver has no way to stall it. A compute word keeps
// busy high until its last result is written back: one multiply-accumulate
// per cycle, set by the single read port of the A and B memories feeding one
// shared multiplier and accumulator. A compute with any dimension zero does nothing.
module matrix_multiply_accumulate (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [mma_pkg::FUNC_W-1:0]            func,
    input  logic [mma_pkg::IDX_W-1:0]             row,
    input  logic [mma_pkg::IDX_W-1:0]             col,
    input  logic signed [mma_pkg::AB_W-1:0]       ab_value,
    input  logic signed [mma_pkg::C_W-1:0]        c_value,
    input  logic                                  cfg_we,
    input  logic [mma_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [mma_pkg::CFG_W-1:0]             cfg_data,
    output logic                                  done,
    output logic signed [mma_pkg::C_W-1:0]        read_value,
    output logic                                  overflow
);
    import mma_pkg::*;

    logic [CFG_W-1:0]       rows_a_reg;
    logic [CFG_W-1:0]       inner_dim_reg;
    logic [CFG_W-1:0]       cols_b_reg;
    logic [CNT_W-1:0]       n_dim;
    logic [CNT_W-1:0]       m_dim;
    logic [CNT_W-1:0]       o_dim;

    logic                   accept;
    logic                   in_range;
    logic [ADDR_W-1:0]      item_addr;
    logic                   a_we;
    logic                   b_we;
    logic                   item_c_we;
    logic                   compute_go;
    logic                   read_go;

    logic                   run_reg;
    logic [DIM_W-1:0]       i_reg;
    logic [DIM_W-1:0]       j_reg;
    logic [DIM_W-1:0]       k_reg;
    logic                   i_last;
    logic                   j_last;
    logic                   k_last;
    mac_tag_t               tag0;
    mac_tag_t               tag1_reg;

    logic signed [AB_W-1:0] mem_a [DEPTH];
    logic signed [AB_W-1:0] mem_b [DEPTH];
    logic signed [C_W-1:0]  mem_c [DEPTH];
    logic [DEPTH-1:0]       c_valid_reg;
    logic signed [AB_W-1:0] a_rd_reg;
    logic signed [AB_W-1:0] b_rd_reg;
    logic signed [C_W-1:0]  c_rd_data_reg;
    logic                   c_rd_valid_reg;
    logic [ADDR_W-1:0]      a_rd_addr;
    logic [ADDR_W-1:0]      b_rd_addr;
    logic [ADDR_W-1:0]      c_rd_addr;
    logic                   c_we;
    logic [ADDR_W-1:0]      c_wr_addr;
    logic signed [C_W-1:0]  c_wr_data;
    logic signed [C_W-1:0]  c_base;

    mac_out_t               mac_out;
    logic                   saturated_reg;
    logic                   done_reg;
    logic                   rd_inside_reg;
    logic                   ovf_out_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg    <= CFG_RESET;
            inner_dim_reg <= CFG_RESET;
            cols_b_reg    <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ROWS_A:    rows_a_reg    <= cfg_data;
                CFG_INNER_DIM: inner_dim_reg <= cfg_data;
                CFG_COLS_B:    cols_b_reg    <= cfg_data;
                default:       ;
            endcase
        end
    end

    assign n_dim = clamp_dim(rows_a_reg);
    assign m_dim = clamp_dim(inner_dim_reg);
    assign o_dim = clamp_dim(cols_b_reg);

    // Command decode.
    always_comb
    begin
        accept     = start & ~busy;
        in_range   = (32'(row) < 32'(MAX_DIM)) && (32'(col) < 32'(MAX_DIM));
        item_addr  = mem_addr(DIM_W'(row), DIM_W'(col));
        a_we       = accept && (func == FUNC_WRITE_A) && in_range;
        b_we       = accept && (func == FUNC_WRITE_B) && in_range;
        item_c_we  = accept && (func == FUNC_WRITE_C) && in_range;
        compute_go = accept && (func == FUNC_COMPUTE) &&
                     (n_dim != '0) && (m_dim != '0) && (o_dim != '0);
        read_go    = accept && (func == FUNC_READ_C);
    end

    // Loop counters: k runs fastest, then j, then i.
    always_comb
    begin
        k_last = (CNT_W'(k_reg) + CNT_W'(1)) == m_dim;
        j_last = (CNT_W'(j_reg) + CNT_W'(1)) == o_dim;
        i_last = (CNT_W'(i_reg) + CNT_W'(1)) == n_dim;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            i_reg   <= '0;
            j_reg   <= '0;
            k_reg   <= '0;
        end
        else if (compute_go)
        begin
            run_reg <= 1'b1;
            i_reg   <= '0;
            j_reg   <= '0;
            k_reg   <= '0;
        end
        else if (run_reg)
        begin
            if (!k_last)
            begin
                k_reg <= k_reg + DIM_W'(1);
            end
            else
            begin
                k_reg <= '0;
                if (!j_last)
                begin
                    j_reg <= j_reg + DIM_W'(1);
                end
                else
                begin
                    j_reg <= '0;
                    if (!i_last)
                    begin
                        i_reg <= i_reg + DIM_W'(1);
                    end
                    else
                    begin
                        i_reg   <= '0;
                        run_reg <= 1'b0;
                    end
                end
            end
        end
    end

    // Step tag issued together with the memory reads.
    always_comb
    begin
        tag0.valid = run_reg;
        tag0.first = (k_reg == '0);
        tag0.last  = k_last;
        tag0.addr  = mem_addr(i_reg, j_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
        end
        else
        begin
            tag1_reg <= tag0;
        end
    end

    // Memory addresses; the C port is shared between reads and the compute.
    always_comb
    begin
        a_rd_addr = mem_addr(i_reg, k_reg);
        b_rd_addr = mem_addr(k_reg, j_reg);
        c_rd_addr = run_reg ? tag0.addr : item_addr;
        c_we      = item_c_we | mac_out.wr_en;
        c_wr_addr = mac_out.wr_en ? mac_out.wr_addr : item_addr;
        c_wr_data = mac_out.wr_en ? mac_out.wr_data : c_value;
        c_base    = c_rd_valid_reg ? c_rd_data_reg : '0;
    end

    // A and B memories.
    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            mem_a[item_addr] <= ab_value;
        end
        a_rd_reg <= mem_a[a_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (b_we)
        begin
            mem_b[item_addr] <= ab_value;
        end
        b_rd_reg <= mem_b[b_rd_addr];
    end

    // C memory.
    always_ff @(posedge clk)
    begin
        if (c_we)
        begin
            mem_c[c_wr_addr] <= c_wr_data;
        end
        c_rd_data_reg <= mem_c[c_rd_addr];
    end

    // Per-entry valid bits make unwritten C entries read as zero after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg    <= '0;
            c_rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (c_we)
            begin
                c_valid_reg[c_wr_addr] <= 1'b1;
            end
            c_rd_valid_reg <= c_valid_reg[c_rd_addr];
        end
    end

    mma_mac u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .tag     (tag1_reg),
        .a_data  (a_rd_reg),
        .b_data  (b_rd_reg),
        .c_base  (c_base),
        .mac_out (mac_out)
    );

    // Sticky overflow flag and the read result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            saturated_reg <= 1'b0;
            done_reg      <= 1'b0;
            rd_inside_reg <= 1'b0;
            ovf_out_reg   <= 1'b0;
        end
        else
        begin
            if (mac_out.sat)
            begin
                saturated_reg <= 1'b1;
            end
            done_reg <= read_go;
            if (read_go)
            begin
                rd_inside_reg <= in_range;
                ovf_out_reg   <= saturated_reg;
            end
        end
    end

    assign busy       = run_reg | tag1_reg.valid | mac_out.active;
    assign done       = done_reg;
    assign read_value = (rd_inside_reg && c_rd_valid_reg) ? c_rd_data_reg : '0;
    assign overflow   = ovf_out_reg;

`ifndef NO_ASSERTIONS
    // A result word only follows a taken read command.
    a_done_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy && (func == FUNC_READ_C)))
        else $error("result strobe without a read command");

    // The overflow flag never clears once set.
    a_sat_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        $past(saturated_reg) |-> saturated_reg)
        else $error("overflow flag cleared");

    // A command write to C never collides with a compute write-back.
    a_c_port_free: assert property (@(posedge clk) disable iff (!rst_n)
        !(item_c_we && mac_out.wr_en))
        else $error("C write port collision");

    // The inner counter stays inside the inner dimension during a compute.
    a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg |-> (CNT_W'(k_reg) < m_dim))
        else $error("inner counter out of range");
`endif

endmodule

FILE: rtl/core/mma_mac.sv
module mma_mac (
    input  logic                               clk,
    input  logic                               rst_n,
    input  mma_pkg::mac_tag_t                  tag,
    input  logic signed [mma_pkg::AB_W-1:0]    a_data,
    input  logic signed [mma_pkg::AB_W-1:0]    b_data,
    input  logic signed [mma_pkg::C_W-1:0]     c_base,
    output mma_pkg::mac_out_t                  mac_out
);
    import mma_pkg::*;

    mac_tag_t                 tag2_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [C_W-1:0]    base_reg;
    logic signed [C_W-1:0]    acc_reg;
    logic signed [C_W-1:0]    acc_in;
    logic signed [C_W:0]      sum;
    logic                     ovf;
    logic signed [C_W-1:0]    acc_sat;

    // Tag follows the product stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag2_reg <= '0;
        end
        else
        begin
            tag2_reg <= tag;
        end
    end

    // Product register, starting value of C and running sum.
    always_ff @(posedge clk)
    begin
        prod_reg <= a_data * b_data;
        base_reg <= c_base;
        if (tag2_reg.valid)
        begin
            acc_reg <= acc_sat;
        end
    end

    // One saturating add per step; the first step starts from the stored C.
    always_comb
    begin
        acc_in  = tag2_reg.first ? base_reg : acc_reg;
        sum     = (C_W + 1)'(acc_in) + (C_W + 1)'(prod_reg);
        ovf     = sum[C_W] ^ sum[C_W-1];
        acc_sat = ovf ? (sum[C_W] ? C_MIN : C_MAX) : sum[C_W-1:0];
    end

    // Write back the element after its last step.
    always_comb
    begin
        mac_out.active  = tag2_reg.valid;
        mac_out.wr_en   = tag2_reg.valid & tag2_reg.last;
        mac_out.wr_addr = tag2_reg.addr;
        mac_out.wr_data = acc_sat;
        mac_out.sat     = tag2_reg.valid & ovf;
    end

endmodule
